FILE: rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg: shared types and constants for the PCM sine fade unit
// Phase and gain sizing, register indexes, sample formats, quarter-sine ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

	localparam int PHASE_BITS  = 24;
	localparam int TABLE_DEPTH = 256;   // power of two
	localparam int GAIN_BITS   = 16;

	localparam int PHASE_W  = PHASE_BITS + 1;
	localparam int TBL_BITS = $clog2(TABLE_DEPTH);
	localparam int IDX_W    = TBL_BITS + 1;
	localparam int GAIN_W   = GAIN_BITS + 1;
	localparam int SAMPLE_W = 32;

	localparam logic [PHASE_W-1:0] FULL_PHASE = PHASE_W'(1) << PHASE_BITS;
	localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(1) << GAIN_BITS;

	// (pi/2)^n / n! in Q30
	localparam logic [63:0] SC1  = 64'd1686629713;
	localparam logic [63:0] SC3  = 64'd693598669;
	localparam logic [63:0] SC5  = 64'd85569306;
	localparam logic [63:0] SC7  = 64'd5026995;
	localparam logic [63:0] SC9  = 64'd172273;
	localparam logic [63:0] SC11 = 64'd3864;

	typedef enum logic [1:0] {
		REG_FADE_DIR      = 2'd0,
		REG_SAMPLE_FORMAT = 2'd1,
		REG_PHASE_STEP    = 2'd2
	} cfg_reg_e;

	typedef enum logic [1:0] {
		FMT_S8  = 2'd0,
		FMT_S16 = 2'd1,
		FMT_S24 = 2'd2,
		FMT_S32 = 2'd3
	} fmt_e;

	typedef struct packed {
		logic               fade_dir;
		fmt_e               fmt;
		logic [PHASE_W-1:0] phase_step;
	} cfg_t;

	// stage 1 -> stage 2 payload
	typedef struct packed {
		logic                neg;
		logic [SAMPLE_W-1:0] mag;
		logic [GAIN_W-1:0]   gain;
		logic                done;
		fmt_e                fmt;
	} s1_t;

	typedef logic [GAIN_W-1:0] gain_rom_t [0:TABLE_DEPTH];

	// Quarter sine, odd Horner polynomial in Q30, rounded to GAIN_BITS.
	function automatic gain_rom_t build_gain_rom();
		gain_rom_t   rom;
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] p;
		logic [63:0] g;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			x = 64'(k) << (30 - TBL_BITS);
			s = (x * x) >> 30;
			p = SC11;
			p = SC9 - ((s * p) >> 30);
			p = SC7 - ((s * p) >> 30);
			p = SC5 - ((s * p) >> 30);
			p = SC3 - ((s * p) >> 30);
			p = SC1 - ((s * p) >> 30);
			p = (p * x) >> 30;
			g = ((p << GAIN_BITS) + (64'd1 << 29)) >> 30;
			if (g > 64'(GAIN_ONE)) begin
				g = 64'(GAIN_ONE);
			end
			rom[k] = g[GAIN_W-1:0];
		end
		rom[0]           = '0;
		rom[TABLE_DEPTH] = GAIN_ONE;
		return rom;
	endfunction

	localparam gain_rom_t GAIN_ROM = build_gain_rom();

endpackage

`default_nettype wire

FILE: rtl/psf_front.sv
// ----------------------------------------------------------------------------
// psf_front: phase accumulator and first pipeline stage
// Applies restart, looks up the gain, splits the sample into sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_front import psf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] sample_in,
	input  wire logic                restart,
	input  wire logic                next_ready,
	output logic                     valid_s1,
	output s1_t                      stage_s1
);

	logic               accept;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_cur;
	logic [PHASE_W-1:0] phase_sel;
	logic [PHASE_W:0]   phase_sum;
	logic [IDX_W-1:0]   idx;
	logic [SAMPLE_W:0]  sext;
	logic [SAMPLE_W:0]  sext_neg;
	s1_t                stage_d;

	assign in_ready = !valid_s1 || next_ready;
	assign accept   = in_valid && in_ready;

	assign phase_cur = restart ? '0 : phase_q;
	assign phase_sel = cfg.fade_dir ? (FULL_PHASE - phase_cur) : phase_cur;
	assign idx       = phase_sel[PHASE_BITS -: IDX_W];
	assign phase_sum = {1'b0, phase_cur} + {1'b0, cfg.phase_step};

	always_comb begin
		case (cfg.fmt)
			FMT_S8:  sext = {{(SAMPLE_W-7){sample_in[7]}}, sample_in[7:0]};
			FMT_S16: sext = {{(SAMPLE_W-15){sample_in[15]}}, sample_in[15:0]};
			FMT_S24: sext = {{(SAMPLE_W-23){sample_in[23]}}, sample_in[23:0]};
			FMT_S32: sext = {sample_in[SAMPLE_W-1], sample_in};
			default: sext = '0;
		endcase
		sext_neg      = (SAMPLE_W + 1)'(0) - sext;
		stage_d.neg   = sext[SAMPLE_W];
		stage_d.mag   = sext[SAMPLE_W] ? sext_neg[SAMPLE_W-1:0] : sext[SAMPLE_W-1:0];
		stage_d.gain  = GAIN_ROM[idx];
		stage_d.done  = (phase_cur == FULL_PHASE);
		stage_d.fmt   = cfg.fmt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				// saturate at full scale
				phase_q <= (phase_sum >= {1'b0, FULL_PHASE}) ? FULL_PHASE
					: phase_sum[PHASE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_d;
		end
	end

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= FULL_PHASE)
		else $error("phase above full scale");

	a_restart_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart |=> phase_q == (($past(cfg.phase_step) >= FULL_PHASE)
			? FULL_PHASE : $past(cfg.phase_step)))
		else $error("phase after restart wrong");

	a_done_gain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && stage_s1.done |->
			stage_s1.gain == (cfg.fade_dir ? GAIN_W'(0) : GAIN_ONE))
		else $error("gain at end of fade wrong");

endmodule

`default_nettype wire

FILE: rtl/psf_scale.sv
// ----------------------------------------------------------------------------
// psf_scale: gain multiply and output register
// Scales the magnitude, restores the sign, packs to the sample format.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_scale import psf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s1,
	input  wire s1_t                 stage_s1,
	output logic                     in_ready,
	output logic                     valid_s2,
	input  wire logic                out_ready,
	output logic [SAMPLE_W-1:0]      data_s2,
	output logic                     done_s2
);

	logic                         load;
	logic [SAMPLE_W+GAIN_W-1:0]   prod_full;
	logic [SAMPLE_W-1:0]          prod;
	logic [SAMPLE_W-1:0]          signed_res;
	logic [SAMPLE_W-1:0]          fmask;

	assign in_ready = !valid_s2 || out_ready;
	assign load     = valid_s1 && in_ready;

	// gain <= 1.0, so the truncated product fits the magnitude width
	assign prod_full  = (SAMPLE_W + GAIN_W)'(stage_s1.mag) * (SAMPLE_W + GAIN_W)'(stage_s1.gain);
	assign prod       = prod_full[GAIN_BITS +: SAMPLE_W];
	assign signed_res = stage_s1.neg ? (SAMPLE_W'(0) - prod) : prod;

	always_comb begin
		case (stage_s1.fmt)
			FMT_S8:  fmask = SAMPLE_W'(32'h0000_00FF);
			FMT_S16: fmask = SAMPLE_W'(32'h0000_FFFF);
			FMT_S24: fmask = SAMPLE_W'(32'h00FF_FFFF);
			FMT_S32: fmask = SAMPLE_W'(32'hFFFF_FFFF);
			default: fmask = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= signed_res & fmask;
			done_s2 <= stage_s1.done;
		end
	end

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		load && stage_s1.gain == '0 |=> data_s2 == '0)
		else $error("zero gain gave nonzero sample");

	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> ($past(stage_s1.fmt) != FMT_S8 || data_s2[31:8] == '0) &&
			($past(stage_s1.fmt) != FMT_S16 || data_s2[31:16] == '0) &&
			($past(stage_s1.fmt) != FMT_S24 || data_s2[31:24] == '0))
		else $error("bits above sample format not zero");

endmodule

`default_nettype wire

FILE: rtl/pcm_sine_fade_unit.sv
// ----------------------------------------------------------------------------
// pcm_sine_fade_unit: sine / cosine fade gain on a PCM sample stream
// Config registers, front stage (phase, gain lookup), scale stage (multiply).
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    tdata: sample_in[31:0]; tuser: restart
//  m_*       out   m_tvalid/m_tready    tdata: sample_out[31:0]; tuser: fade_done
//  cfg_*     in    cfg_valid/cfg_ready  cfg_index (0 dir, 1 format, 2 step), cfg_data
//
//  One item per cycle while m_tready allows; m_tvalid rises once an accepted
//  item has passed the stage 1 register and the output register.
//  Stages: gain ROM lookup, then the 32x17 multiply into the output register.
//  The phase accumulator advances on each accepted item, so it sets no limit.
//  Reset clears phase, valid bits and registers (dir 0, format S16, step 0).
//  A stall on m_tready fills stage 1, then drops s_tready.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_sine_fade_unit import psf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SAMPLE_W-1:0] s_tdata,    // [31:0] sample_in
	input  wire logic                s_tuser,    // [0] restart
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [SAMPLE_W-1:0]      m_tdata,    // [31:0] sample_out
	output logic                     m_tuser,    // [0] fade_done
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [PHASE_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	s1_t  stage_s1;
	logic scale_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fade_dir   <= 1'b0;
			cfg_q.fmt        <= FMT_S16;
			cfg_q.phase_step <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_e'(cfg_index))
				REG_FADE_DIR:      cfg_q.fade_dir   <= cfg_data[0];
				REG_SAMPLE_FORMAT: cfg_q.fmt        <= fmt_e'(cfg_data[1:0]);
				REG_PHASE_STEP:    cfg_q.phase_step <= cfg_data;
				default: ;
			endcase
		end
	end

	psf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.sample_in  (s_tdata),
		.restart    (s_tuser),
		.next_ready (scale_ready),
		.valid_s1   (valid_s1),
		.stage_s1   (stage_s1)
	);

	psf_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.stage_s1  (stage_s1),
		.in_ready  (scale_ready),
		.valid_s2  (m_tvalid),
		.out_ready (m_tready),
		.data_s2   (m_tdata),
		.done_s2   (m_tuser)
	);

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !scale_ready |=> valid_s1)
		else $error("stage 1 item lost while stalled");

endmodule

`default_nettype wire

FILE: verif/pcm_sine_fade_unit_test.sv
// ----------------------------------------------------------------------------
// pcm_sine_fade_unit_test: stream-level check of the PCM sine fade unit
// Drives sample items and register writes, predicts every faded sample and
// its done flag from an independent gain table and phase model, and compares
// each output item in order. Both sides idle at random, with one long stall.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_sine_fade_unit_test;
	import psf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 173;

	localparam logic [1:0] REG_SPARE = 2'd3;   // no register at this index

	localparam longint unsigned PHASE_FULL = 64'd1 << PHASE_BITS;
	localparam longint unsigned UNITY_GAIN = 64'd1 << GAIN_BITS;

	// Taylor terms (pi/2)^n / n!, Q30
	localparam longint unsigned K1  = 64'd1686629713;
	localparam longint unsigned K3  = 64'd693598669;
	localparam longint unsigned K5  = 64'd85569306;
	localparam longint unsigned K7  = 64'd5026995;
	localparam longint unsigned K9  = 64'd172273;
	localparam longint unsigned K11 = 64'd3864;

	typedef struct {
		logic [SAMPLE_W-1:0] word;
		logic                restart;
	} pcm_item_t;

	typedef struct {
		logic [SAMPLE_W-1:0] pcm;
		logic                done;
	} faded_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata   = '0;
	logic                s_tuser   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [PHASE_W-1:0]  cfg_data  = '0;

	pcm_item_t pending_q[$];
	faded_t    faded_q[$];

	// fade model state
	longint unsigned gain_lut [0:TABLE_DEPTH];
	longint unsigned phase_r = 0;
	longint unsigned step_r  = 0;
	logic            dir_r   = 1'b0;
	fmt_e            fmt_r   = FMT_S16;

	int          err_count   = 0;
	int          cycle_count = 0;
	int          src_gap     = 0;
	int unsigned snk_wait    = 0;
	int          hold_cycles = 0;
	bit          src_steady  = 1'b1;
	bit          snk_steady  = 1'b1;

	pcm_sine_fade_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// quarter-sine gain, odd Horner series in Q30, rounded to the gain width
	function automatic longint unsigned sine_gain(int k);
		longint unsigned x, xx, acc, g;
		x   = (64'(k) << 30) / TABLE_DEPTH;
		xx  = (x * x) >> 30;
		acc = K11;
		acc = K9 - ((xx * acc) >> 30);
		acc = K7 - ((xx * acc) >> 30);
		acc = K5 - ((xx * acc) >> 30);
		acc = K3 - ((xx * acc) >> 30);
		acc = K1 - ((xx * acc) >> 30);
		acc = (acc * x) >> 30;
		g   = ((acc << GAIN_BITS) + (64'd1 << 29)) >> 30;
		return (g > UNITY_GAIN) ? UNITY_GAIN : g;
	endfunction

	task automatic apply_fade(input logic [SAMPLE_W-1:0] word, input logic restart);
		int unsigned     bits;
		longint unsigned fmask, raw, mag, pos, idx, prod, res, nxt;
		logic            neg;
		faded_t          want;
		bits  = 8 * (int'(fmt_r) + 1);
		fmask = (64'd1 << bits) - 1;
		raw   = 64'(word) & fmask;
		neg   = raw[bits-1];
		mag   = neg ? ((64'd1 << bits) - raw) : raw;
		if (restart) begin
			phase_r = 0;
		end
		if (phase_r > PHASE_FULL) begin
			phase_r = PHASE_FULL;
		end
		// fade-out reads the table mirrored: cos(p) = sin(1 - p)
		pos = dir_r ? (PHASE_FULL - phase_r) : phase_r;
		idx = (pos * TABLE_DEPTH) >> PHASE_BITS;
		if (idx > TABLE_DEPTH) begin
			idx = TABLE_DEPTH;
		end
		prod = (mag * gain_lut[idx]) >> GAIN_BITS;
		res  = neg ? ((64'd0 - prod) & fmask) : (prod & fmask);
		want.pcm  = res[SAMPLE_W-1:0];
		want.done = (phase_r == PHASE_FULL);
		faded_q.push_back(want);
		nxt     = phase_r + step_r;
		phase_r = (nxt >= PHASE_FULL) ? PHASE_FULL : nxt;
	endtask

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
			input logic [SAMPLE_W-1:0] want);
		$display("ERROR @%0t %0s: got %h, expected %h", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_word(fmt_e f);
		int unsigned     bits;
		longint unsigned fmask, body;
		bits  = 8 * (int'(f) + 1);
		fmask = (64'd1 << bits) - 1;
		case ($urandom_range(0, 7))
			0: body = fmask >> 1;
			1: body = (fmask >> 1) + 1;
			2: body = fmask;
			3: body = 0;
			default: body = 64'($urandom) & fmask;
		endcase
		// junk above the format width must be ignored
		return SAMPLE_W'((64'($urandom) & ~fmask) | body);
	endfunction

	task automatic queue_item(input logic [SAMPLE_W-1:0] word, input logic restart);
		pcm_item_t it;
		it.word    = word;
		it.restart = restart;
		pending_q.push_back(it);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [PHASE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || faded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sample driver
	always @(posedge clk) begin
		pcm_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				s_tvalid <= 1'b0;
				src_gap  <= src_gap - 1;
			end else if (pending_q.size() != 0) begin
				nxt = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= nxt.word;
				s_tuser  <= nxt.restart;
				src_gap  <= src_steady ? 0 : $urandom_range(0, 3);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(posedge clk) begin
		int unsigned w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				w = snk_steady ? 0 : $urandom_range(0, 3);
			end else begin
				w = (snk_wait != 0) ? snk_wait - 1 : 0;
			end
			snk_wait <= w;
			m_tready <= (w == 0) && (hold_cycles <= 1);
		end
	end

	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// register writes and accepted samples feed the model
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FADE_DIR:      dir_r  = cfg_data[0];
				REG_SAMPLE_FORMAT: fmt_r  = fmt_e'(cfg_data[1:0]);
				REG_PHASE_STEP:    step_r = 64'(cfg_data);
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			apply_fade(s_tdata, s_tuser);
		end
	end

	always @(posedge clk) begin
		faded_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (faded_q.size() == 0) begin
				report_mismatch("unexpected item", m_tdata, '0);
			end else begin
				want = faded_q.pop_front();
				if (m_tdata !== want.pcm) begin
					report_mismatch("sample_out", m_tdata, want.pcm);
				end
				if (m_tuser !== want.done) begin
					report_mismatch("fade_done", SAMPLE_W'(m_tuser), SAMPLE_W'(want.done));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		longint unsigned step;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			gain_lut[k] = sine_gain(k);
		end
		gain_lut[0]           = 0;
		gain_lut[TABLE_DEPTH] = UNITY_GAIN;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: fade-in at phase zero, every sample comes out zero
		queue_item(32'h0000_7FFF, 1'b0);
		queue_item(32'hFFFF_8000, 1'b0);
		queue_item(32'hFFFF_FFFF, 1'b1);
		drain();

		// fade-out at phase zero is unity gain; junk above 8 bits dropped
		write_reg(REG_FADE_DIR, PHASE_W'(1));
		write_reg(REG_SAMPLE_FORMAT, PHASE_W'(FMT_S8));
		queue_item(32'h0000_007F, 1'b0);
		queue_item(32'h0000_0080, 1'b0);
		queue_item(32'hABCD_EF80, 1'b0);
		queue_item(32'hFFFF_FFFF, 1'b0);
		queue_item(32'h1234_5600, 1'b0);
		drain();

		// quarter-scale steps up to full scale, then saturation
		write_reg(REG_SAMPLE_FORMAT, PHASE_W'(FMT_S32));
		write_reg(REG_FADE_DIR, PHASE_W'(0));
		write_reg(REG_PHASE_STEP, PHASE_W'(1) << (PHASE_BITS - 2));
		queue_item(32'h7FFF_FFFF, 1'b1);
		queue_item(32'h8000_0000, 1'b0);
		queue_item(32'hFFFF_FFFF, 1'b0);
		queue_item(32'h7FFF_FFFF, 1'b0);
		queue_item(32'h8000_0000, 1'b0);
		queue_item(32'h1234_5678, 1'b0);
		drain();

		// direction flip at full phase, write to a hole, oversized step
		write_reg(REG_FADE_DIR, PHASE_W'(1));
		write_reg(REG_SPARE, '1);
		write_reg(REG_SAMPLE_FORMAT, PHASE_W'(FMT_S24));
		write_reg(REG_PHASE_STEP, '1);
		queue_item(32'h5A7F_FFFF, 1'b0);
		queue_item(32'h0080_0000, 1'b1);
		queue_item(32'hFF7F_FFFF, 1'b0);
		queue_item(32'hA580_0001, 1'b1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 5)
				0: step = PHASE_FULL / $urandom_range(20, 200);
				1: step = 1;
				2: step = 0;
				3: step = PHASE_FULL;
				default: step = 64'($urandom);
			endcase
			write_reg(REG_FADE_DIR, PHASE_W'($urandom_range(0, 1)));
			write_reg(REG_SAMPLE_FORMAT, PHASE_W'(ph % 4));
			write_reg(REG_PHASE_STEP, PHASE_W'(step));
			src_steady = (ph % 3 == 0);
			snk_steady = (ph % 4 == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				queue_item(pick_word(fmt_e'(ph % 4)), $urandom_range(0, 47) == 0);
			end
			// long output stall while the sender keeps offering
			if (ph == 3) begin
				hold_cycles <= 400;
			end
			drain();
		end

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/psf_pkg.sv
rtl/psf_front.sv
rtl/psf_scale.sv
rtl/pcm_sine_fade_unit.sv
verif/pcm_sine_fade_unit_test.sv
